@@ src/imapstd_pkg.sv @@
// Shared types and constants of the IMAP string token decoder.
// Holds the result beat layout, the result queue sizing and byte codes.
// No dependencies.
`default_nettype none

package imapstd_pkg;

    // One result beat as it leaves the block
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       token_end;
        logic [1:0] token_kind;
        logic       bad_escape;
        logic [7:0] stop_byte;
    } result_t;

    // Results one input byte can cause, and result queue sizing
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;
    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    // Token kinds
    localparam logic [1:0] KIND_QUOTED  = 2'd0;
    localparam logic [1:0] KIND_ATOM    = 2'd1;
    localparam logic [1:0] KIND_LITERAL = 2'd2;
    localparam logic [1:0] KIND_NIL     = 2'd3;

    // Byte codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    // Letters of the word NIL by position
    function automatic logic [7:0] nil_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4E;
            2'd1:    c = 8'h49;
            2'd2:    c = 8'h4C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/imapstd_fifo.sv @@
// Result queue of the IMAP string token decoder: takes up to four beats
// per cycle and releases one per cycle while pop is high.
// Depends on imapstd_pkg.
`default_nettype none

module imapstd_fifo (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [imapstd_pkg::RES_CNT_W-1:0]      push_cnt,
    input  wire imapstd_pkg::result_t [imapstd_pkg::MAX_RESULTS-1:0] push_data,
    output logic                                        room,
    input  wire logic                                   pop,
    output logic                                        valid,
    output imapstd_pkg::result_t                        head
);

    localparam int QD = imapstd_pkg::QDEPTH;
    localparam int PW = imapstd_pkg::QPTR_W;
    localparam int CW = imapstd_pkg::QCNT_W;
    localparam int MR = imapstd_pkg::MAX_RESULTS;
    localparam int RW = imapstd_pkg::RES_CNT_W;

    imapstd_pkg::result_t q_mem [QD];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Occupancy and pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: beat i of this cycle lands at tail + i
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MR; i++)
        begin
            if (RW'(i) < push_cnt)
            begin
                q_mem[wr_ptr_reg + PW'(i)] <= push_data[i];
            end
        end
    end

    // Head beat and room for a worst case input byte
    assign valid = (count_reg != '0);
    assign head  = q_mem[rd_ptr_reg];
    assign room  = (count_reg <= CW'(QD - MR));

    // Occupancy never exceeds the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QD))
        else $error("result queue occupancy beyond depth");

    // A push always fits in the free slots
    assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != '0 |-> ({1'b0, count_reg} + (CW + 1)'(push_cnt) <= (CW + 1)'(QD)))
        else $error("result queue overrun");

    // Nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underrun");

endmodule

`default_nettype wire

@@ src/imap_string_token_decoder.sv @@
// IMAP string token decoder top level: byte parser and result queue.
// Depends on imapstd_pkg and imapstd_fifo.
//
//   Channel  Handshake                 Beat
//   in       in_valid / in_stall       in_byte: one raw command byte
//   out      out_valid / out_stall     byte_valid, out_byte, token_end,
//                                      token_kind, bad_escape, stop_byte
//
// One input byte is taken per cycle while in_stall is low and parsed in the
// same cycle into up to four result beats, written to an 8-entry result queue.
// Results leave the queue one per cycle while out_stall is low.
// in_stall rises while fewer than four queue slots are free, so a NIL
// prefix flush of four beats drains before more bytes enter.
// Reset (rst_n low, asynchronous) returns to the between-tokens state with
// an empty queue.
`default_nettype none

module imap_string_token_decoder #(
    parameter int LITERAL_COUNT_BITS = 31
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            byte_valid,
    output logic [7:0]      out_byte,
    output logic            token_end,
    output logic [1:0]      token_kind,
    output logic            bad_escape,
    output logic [7:0]      stop_byte
);

    localparam int LW = LITERAL_COUNT_BITS;
    localparam int NR = imapstd_pkg::MAX_RESULTS;
    localparam int RW = imapstd_pkg::RES_CNT_W;

    typedef enum logic [2:0] {
        M_IDLE,
        M_QUOTED,
        M_QESC,
        M_COUNT,
        M_LIT_LF,
        M_LIT_DATA,
        M_ATOM,
        M_SKIP_LF
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [LW-1:0] lit_rem_reg, lit_rem_next;
    logic          lit_big_reg, lit_big_next;
    logic [1:0]    nil_held_reg, nil_held_next;
    logic [1:0]    atom_cnt_reg, atom_cnt_next;
    logic          last_bs_reg, last_bs_next;

    logic          take;
    logic          room;
    logic          pop;
    logic [RW-1:0] res_n;
    logic [RW-1:0] push_cnt;
    imapstd_pkg::result_t [NR-1:0] res;
    imapstd_pkg::result_t          head;

    logic          do_idle, do_atom, do_lit;
    logic [1:0]    a_held, a_cnt;
    logic          a_lbs, a_match;
    logic [LW+3:0] count_acc;
    logic [LW-1:0] lit_dec;
    logic [7:0]    b;

    function automatic imapstd_pkg::result_t mk_res(
        input logic       v,
        input logic [7:0] d,
        input logic       e,
        input logic [1:0] k,
        input logic       bad,
        input logic [7:0] s
    );
        imapstd_pkg::result_t r;
        r.byte_valid = v;
        r.out_byte   = d;
        r.token_end  = e;
        r.token_kind = k;
        r.bad_escape = bad;
        r.stop_byte  = s;
        return r;
    endfunction

    function automatic logic is_atom_stop(input logic [7:0] c);
        return (c == imapstd_pkg::CH_SPACE) || (c == imapstd_pkg::CH_LPAREN) ||
               (c == imapstd_pkg::CH_RPAREN) || (c == imapstd_pkg::CH_CR) ||
               (c == imapstd_pkg::CH_LF) || (c == imapstd_pkg::CH_QUOTE);
    endfunction

    assign b    = in_byte;
    assign take = in_valid && !in_stall;

    // Count digit accumulate: x*10 + d, overflow when the top bits are set
    assign count_acc = {1'b0, lit_rem_reg, 3'b000} + {3'b000, lit_rem_reg, 1'b0}
                     + {{LW{1'b0}}, b[3:0]};
    assign lit_dec   = lit_rem_reg - LW'(lit_rem_reg != '0);

    // Parse one byte into next state and result beats
    always_comb
    begin
        mode_next     = mode_reg;
        lit_rem_next  = lit_rem_reg;
        lit_big_next  = lit_big_reg;
        nil_held_next = nil_held_reg;
        atom_cnt_next = atom_cnt_reg;
        last_bs_next  = last_bs_reg;
        res           = '0;
        res_n         = '0;
        do_idle       = 1'b0;
        do_atom       = 1'b0;
        do_lit        = 1'b0;
        a_held        = nil_held_reg;
        a_cnt         = atom_cnt_reg;
        a_lbs         = last_bs_reg;
        a_match       = 1'b0;

        unique case (mode_reg)
            M_QUOTED:
            begin
                if (b == imapstd_pkg::CH_BSLASH)
                begin
                    mode_next = M_QESC;
                end
                else if (b == imapstd_pkg::CH_QUOTE)
                begin
                    res[0]    = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_QUOTED,
                                       1'b0, 8'h00);
                    res_n     = RW'(1);
                    mode_next = M_IDLE;
                end
                else
                begin
                    res[0] = mk_res(1'b1, b, 1'b0, imapstd_pkg::KIND_QUOTED, 1'b0, 8'h00);
                    res_n  = RW'(1);
                end
            end
            M_QESC:
            begin
                mode_next = M_QUOTED;
                res_n     = RW'(1);
                if (b == imapstd_pkg::CH_LOW_R)
                begin
                    res[0] = mk_res(1'b1, imapstd_pkg::CH_CR, 1'b0,
                                    imapstd_pkg::KIND_QUOTED, 1'b0, 8'h00);
                end
                else if (b == imapstd_pkg::CH_LOW_N)
                begin
                    res[0] = mk_res(1'b1, imapstd_pkg::CH_LF, 1'b0,
                                    imapstd_pkg::KIND_QUOTED, 1'b0, 8'h00);
                end
                else if (b == imapstd_pkg::CH_BSLASH || b == imapstd_pkg::CH_QUOTE)
                begin
                    res[0] = mk_res(1'b1, b, 1'b0, imapstd_pkg::KIND_QUOTED, 1'b0, 8'h00);
                end
                else
                begin
                    res[0]    = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_QUOTED,
                                       1'b1, 8'h00);
                    mode_next = M_IDLE;
                end
            end
            M_COUNT:
            begin
                if (b == imapstd_pkg::CH_RBRACE)
                begin
                    lit_big_next = 1'b0;
                    if (lit_big_reg || lit_rem_reg == '0)
                    begin
                        lit_rem_next = '0;
                        res[0]       = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_LITERAL,
                                              1'b0, 8'h00);
                        res_n        = RW'(1);
                        mode_next    = M_SKIP_LF;
                    end
                    else
                    begin
                        mode_next = M_LIT_LF;
                    end
                end
                else if (b >= imapstd_pkg::CH_ZERO && b <= imapstd_pkg::CH_NINE)
                begin
                    if (!lit_big_reg)
                    begin
                        if (count_acc[LW+3:LW] != 4'b0000)
                        begin
                            lit_big_next = 1'b1;
                        end
                        else
                        begin
                            lit_rem_next = count_acc[LW-1:0];
                        end
                    end
                end
                else
                begin
                    lit_big_next = 1'b1;
                end
            end
            M_LIT_LF:
            begin
                if (b == imapstd_pkg::CH_LF)
                begin
                    mode_next = M_LIT_DATA;
                end
                else
                begin
                    do_lit = 1'b1;
                end
            end
            M_LIT_DATA:
            begin
                do_lit = 1'b1;
            end
            M_ATOM:
            begin
                do_atom = 1'b1;
            end
            M_SKIP_LF:
            begin
                if (b == imapstd_pkg::CH_LF)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    do_idle = 1'b1;
                end
            end
            M_IDLE:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Between tokens: pick the token type from its first byte
        if (do_idle)
        begin
            mode_next = M_IDLE;
            if (b == imapstd_pkg::CH_SPACE)
            begin
                mode_next = M_IDLE;
            end
            else if (b == imapstd_pkg::CH_QUOTE)
            begin
                mode_next = M_QUOTED;
            end
            else if (b == imapstd_pkg::CH_LBRACE)
            begin
                mode_next    = M_COUNT;
                lit_rem_next = '0;
                lit_big_next = 1'b0;
            end
            else
            begin
                mode_next = M_ATOM;
                a_held    = 2'd0;
                a_cnt     = 2'd0;
                a_lbs     = 1'b0;
                do_atom   = 1'b1;
            end
        end

        // Literal data byte
        if (do_lit)
        begin
            res[0] = mk_res(1'b1, b, 1'b0, imapstd_pkg::KIND_LITERAL, 1'b0, 8'h00);
            lit_rem_next = lit_dec;
            if (lit_dec == '0)
            begin
                res[1]    = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_LITERAL,
                                   1'b0, 8'h00);
                res_n     = RW'(2);
                mode_next = M_IDLE;
            end
            else
            begin
                res_n     = RW'(1);
                mode_next = M_LIT_DATA;
            end
        end

        // Atom byte: NIL prefix tracking, backslash collapse, terminator
        if (do_atom)
        begin
            a_match = (a_held == a_cnt);
            if (is_atom_stop(b))
            begin
                if (a_match && a_held == 2'd3)
                begin
                    res[0] = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_NIL, 1'b0, b);
                    res_n  = RW'(1);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < a_held)
                        begin
                            res[res_n[1:0]] = mk_res(1'b1, imapstd_pkg::nil_char(2'(i)), 1'b0,
                                                     imapstd_pkg::KIND_ATOM, 1'b0, 8'h00);
                            res_n = res_n + RW'(1);
                        end
                    end
                    res[res_n[1:0]] = mk_res(1'b0, 8'h00, 1'b1, imapstd_pkg::KIND_ATOM,
                                             1'b0, b);
                    res_n = res_n + RW'(1);
                end
                nil_held_next = 2'd0;
                atom_cnt_next = 2'd0;
                last_bs_next  = 1'b0;
                mode_next     = M_IDLE;
            end
            else if (a_match && a_held != 2'd3 && b == imapstd_pkg::nil_char(a_held))
            begin
                nil_held_next = a_held + 2'd1;
                atom_cnt_next = a_cnt + 2'd1;
                last_bs_next  = a_lbs;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < a_held)
                    begin
                        res[res_n[1:0]] = mk_res(1'b1, imapstd_pkg::nil_char(2'(i)), 1'b0,
                                                 imapstd_pkg::KIND_ATOM, 1'b0, 8'h00);
                        res_n = res_n + RW'(1);
                    end
                end
                nil_held_next = 2'd0;
                atom_cnt_next = (a_cnt == 2'd3) ? a_cnt : a_cnt + 2'd1;
                if (!(b == imapstd_pkg::CH_BSLASH && a_lbs))
                begin
                    res[res_n[1:0]] = mk_res(1'b1, b, 1'b0, imapstd_pkg::KIND_ATOM,
                                             1'b0, 8'h00);
                    res_n = res_n + RW'(1);
                end
                last_bs_next = (b == imapstd_pkg::CH_BSLASH);
            end
        end
    end

    // Parser state, advanced only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            lit_rem_reg  <= '0;
            lit_big_reg  <= 1'b0;
            nil_held_reg <= 2'd0;
            atom_cnt_reg <= 2'd0;
            last_bs_reg  <= 1'b0;
        end
        else if (take)
        begin
            mode_reg     <= mode_next;
            lit_rem_reg  <= lit_rem_next;
            lit_big_reg  <= lit_big_next;
            nil_held_reg <= nil_held_next;
            atom_cnt_reg <= atom_cnt_next;
            last_bs_reg  <= last_bs_next;
        end
    end

    // Result queue
    assign push_cnt = take ? res_n : '0;
    assign pop      = out_valid && !out_stall;
    assign in_stall = !room;

    imapstd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (res),
        .room      (room),
        .pop       (pop),
        .valid     (out_valid),
        .head      (head)
    );

    assign byte_valid = head.byte_valid;
    assign out_byte   = head.out_byte;
    assign token_end  = head.token_end;
    assign token_kind = head.token_kind;
    assign bad_escape = head.bad_escape;
    assign stop_byte  = head.stop_byte;

    // Literal data mode always has bytes left to pass
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_LIT_DATA |-> lit_rem_reg != '0)
        else $error("literal data mode with zero count");

    // NIL bytes are only held inside an atom, and only while all bytes matched
    assert property (@(posedge clk) disable iff (!rst_n)
        nil_held_reg != 2'd0 |-> (mode_reg == M_ATOM && nil_held_reg == atom_cnt_reg))
        else $error("NIL prefix held outside a matching atom");

    // Overflow flag only lives while a count is being read
    assert property (@(posedge clk) disable iff (!rst_n)
        lit_big_reg |-> mode_reg == M_COUNT)
        else $error("literal overflow flag outside count");

endmodule

`default_nettype wire

@@ tb/sv/imap_token_checker.sv @@
// Result checker for the IMAP string token decoder: tracks the byte parser
// from accepted input beats and compares every accepted result beat.
// Depends on imapstd_pkg for the byte codes and token kinds.
module imap_token_checker #(
    parameter int COUNT_BITS = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       byte_valid,
    input  logic [7:0] out_byte,
    input  logic       token_end,
    input  logic [1:0] token_kind,
    input  logic       bad_escape,
    input  logic [7:0] stop_byte,
    output int         fail_count,
    output int         awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import imapstd_pkg::*;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_QUOTED,
        PS_QESC,
        PS_COUNT,
        PS_LIT_LF,
        PS_LIT_DATA,
        PS_ATOM,
        PS_SKIP_LF
    } parse_state_t;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [23:0] NIL_WORD  = "NIL";

    // Parser state as seen from the byte stream
    parse_state_t pstate      = PS_IDLE;
    logic [63:0]  lit_count   = '0;
    logic         count_bad   = 1'b0;
    logic [1:0]   nil_held    = '0;
    logic         prev_bslash = 1'b0;
    logic [1:0]   atom_len    = '0;

    result_t decoded_q[$];
    result_t want;
    int      mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [7:0] nil_letter(input int idx);
        return NIL_WORD[23 - 8 * idx -: 8];
    endfunction

    function automatic void push_beat(input logic bv, input logic [7:0] b, input logic e,
                                      input logic [1:0] k, input logic bad,
                                      input logic [7:0] stop);
        result_t r;
        r.byte_valid = bv;
        r.out_byte   = b;
        r.token_end  = e;
        r.token_kind = k;
        r.bad_escape = bad;
        r.stop_byte  = stop;
        decoded_q.push_back(r);
    endfunction

    function automatic logic ends_atom(input logic [7:0] b);
        return b == CH_SPACE || b == CH_LPAREN || b == CH_RPAREN || b == CH_CR ||
               b == CH_LF || b == CH_QUOTE;
    endfunction

    // Release the NIL letters held back so far as plain atom bytes
    function automatic void release_nil();
        int i;
        for (i = 0; i < nil_held; i++)
            push_beat(1'b1, nil_letter(i), 1'b0, KIND_ATOM, 1'b0, 8'h00);
    endfunction

    function automatic void atom_byte(input logic [7:0] b);
        logic matching;
        matching = (nil_held == atom_len);
        // terminator closes the atom, or the NIL token on a full match
        if (ends_atom(b))
        begin
            if (matching && nil_held == 2'd3)
                push_beat(1'b0, 8'h00, 1'b1, KIND_NIL, 1'b0, b);
            else
            begin
                release_nil();
                push_beat(1'b0, 8'h00, 1'b1, KIND_ATOM, 1'b0, b);
            end
            nil_held    = '0;
            atom_len    = '0;
            prev_bslash = 1'b0;
            pstate      = PS_IDLE;
            return;
        end
        // still spelling NIL: hold the byte
        if (matching && nil_held < 2'd3 && b == nil_letter(nil_held))
        begin
            nil_held++;
            atom_len++;
            return;
        end
        release_nil();
        nil_held = '0;
        if (atom_len < 2'd3)
            atom_len++;
        // a run of backslashes comes out as one
        if (b == CH_BSLASH)
        begin
            if (!prev_bslash)
                push_beat(1'b1, b, 1'b0, KIND_ATOM, 1'b0, 8'h00);
            prev_bslash = 1'b1;
        end
        else
        begin
            push_beat(1'b1, b, 1'b0, KIND_ATOM, 1'b0, 8'h00);
            prev_bslash = 1'b0;
        end
    endfunction

    function automatic void token_start(input logic [7:0] b);
        pstate = PS_IDLE;
        if (b == CH_SPACE)
            return;
        if (b == CH_QUOTE)
        begin
            pstate = PS_QUOTED;
            return;
        end
        if (b == CH_LBRACE)
        begin
            pstate    = PS_COUNT;
            lit_count = '0;
            count_bad = 1'b0;
            return;
        end
        pstate      = PS_ATOM;
        nil_held    = '0;
        atom_len    = '0;
        prev_bslash = 1'b0;
        atom_byte(b);
    endfunction

    function automatic void literal_byte(input logic [7:0] b);
        push_beat(1'b1, b, 1'b0, KIND_LITERAL, 1'b0, 8'h00);
        if (lit_count > 0)
            lit_count--;
        if (lit_count == 0)
        begin
            push_beat(1'b0, 8'h00, 1'b1, KIND_LITERAL, 1'b0, 8'h00);
            pstate = PS_IDLE;
        end
        else
            pstate = PS_LIT_DATA;
    endfunction

    // Advance the parser by one raw byte and queue the beats it yields
    function automatic void decode_byte(input logic [7:0] b);
        logic [63:0] digit;
        case (pstate)
            PS_QUOTED:
                if (b == CH_BSLASH)
                    pstate = PS_QESC;
                else if (b == CH_QUOTE)
                begin
                    push_beat(1'b0, 8'h00, 1'b1, KIND_QUOTED, 1'b0, 8'h00);
                    pstate = PS_IDLE;
                end
                else
                    push_beat(1'b1, b, 1'b0, KIND_QUOTED, 1'b0, 8'h00);
            PS_QESC:
            begin
                pstate = PS_QUOTED;
                if (b == CH_LOW_R)
                    push_beat(1'b1, CH_CR, 1'b0, KIND_QUOTED, 1'b0, 8'h00);
                else if (b == CH_LOW_N)
                    push_beat(1'b1, CH_LF, 1'b0, KIND_QUOTED, 1'b0, 8'h00);
                else if (b == CH_BSLASH || b == CH_QUOTE)
                    push_beat(1'b1, b, 1'b0, KIND_QUOTED, 1'b0, 8'h00);
                else
                begin
                    push_beat(1'b0, 8'h00, 1'b1, KIND_QUOTED, 1'b1, 8'h00);
                    pstate = PS_IDLE;
                end
            end
            PS_COUNT:
                if (b == CH_RBRACE)
                begin
                    if (count_bad)
                        lit_count = '0;
                    count_bad = 1'b0;
                    if (lit_count == 0)
                    begin
                        push_beat(1'b0, 8'h00, 1'b1, KIND_LITERAL, 1'b0, 8'h00);
                        pstate = PS_SKIP_LF;
                    end
                    else
                        pstate = PS_LIT_LF;
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    digit = {56'd0, b - CH_ZERO};
                    if (!count_bad)
                    begin
                        if (lit_count > (COUNT_MAX - digit) / 10)
                            count_bad = 1'b1;
                        else
                            lit_count = lit_count * 10 + digit;
                    end
                end
                else
                    count_bad = 1'b1;
            PS_LIT_LF:
                if (b == CH_LF)
                    pstate = PS_LIT_DATA;
                else
                    literal_byte(b);
            PS_LIT_DATA:
                literal_byte(b);
            PS_ATOM:
                atom_byte(b);
            PS_SKIP_LF:
                if (b == CH_LF)
                    pstate = PS_IDLE;
                else
                    token_start(b);
            default:
                token_start(b);
        endcase
        lit_count &= COUNT_MAX;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Track input beats, then match output beats in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstate      = PS_IDLE;
            lit_count   = '0;
            count_bad   = 1'b0;
            nil_held    = '0;
            prev_bslash = 1'b0;
            atom_len    = '0;
            decoded_q.delete();
            awaited <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(in_byte);
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("byte_valid", want.byte_valid, byte_valid);
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("token_end", want.token_end, token_end);
                    check_field("token_kind", want.token_kind, token_kind);
                    check_field("bad_escape", want.bad_escape, bad_escape);
                    check_field("stop_byte", want.stop_byte, stop_byte);
                end
            end
            awaited <= decoded_q.size();
        end
    end

endmodule

@@ tb/sv/imap_string_token_decoder_test.sv @@
// Top of the IMAP string token decoder testbench: clock, reset, byte
// stimulus and output stall, with the result checker beside the block.
// Depends on imapstd_pkg, imap_string_token_decoder and imap_token_checker.
module imap_string_token_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import imapstd_pkg::*;

    localparam int COUNT_BITS   = 31;
    localparam int RANDOM_BYTES = 260;
    localparam int PERIOD       = 10;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte    = 8'h00;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       token_end;
    logic [1:0] token_kind;
    logic       bad_escape;
    logic [7:0] stop_byte;

    int   fail_count;
    int   awaited;
    int   sent_bytes = 0;
    int   stall_left = 0;
    int   stall_pick;
    logic quiet      = 1'b0;

    imap_string_token_decoder #(
        .LITERAL_COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_valid(byte_valid),
        .out_byte  (out_byte),
        .token_end (token_end),
        .token_kind(token_kind),
        .bad_escape(bad_escape),
        .stop_byte (stop_byte)
    );

    imap_token_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_valid(byte_valid),
        .out_byte  (out_byte),
        .token_end (token_end),
        .token_kind(token_kind),
        .bad_escape(bad_escape),
        .stop_byte (stop_byte),
        .fail_count(fail_count),
        .awaited   (awaited)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Receiver stall: mostly short bursts, now and then a long one
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 70)
                out_stall <= 1'b0;
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One input beat, held until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Hold input until every outstanding result has left
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    task automatic send_quoted();
        int         len;
        int         i;
        int         pick;
        logic [7:0] b;
        send_byte(CH_QUOTE);
        len = $urandom_range(0, 6);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                send_byte(CH_BSLASH);
                case ($urandom_range(0, 3))
                    0:       b = CH_LOW_R;
                    1:       b = CH_LOW_N;
                    2:       b = CH_BSLASH;
                    default: b = CH_QUOTE;
                endcase
                send_byte(b);
            end
            else if (pick < 25)
            begin
                // unsupported escape closes the token
                send_byte(CH_BSLASH);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_LOW_R || b == CH_LOW_N || b == CH_BSLASH || b == CH_QUOTE);
                send_byte(b);
                return;
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                send_byte(b);
            end
        end
        send_byte(CH_QUOTE);
    endtask

    task automatic send_literal();
        int         pick;
        int         len;
        int         i;
        logic       lf_sent;
        logic [7:0] b;
        len  = 0;
        pick = $urandom_range(0, 99);
        send_byte(CH_LBRACE);
        if (pick < 70)
        begin
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                send_text("0");
            send_text($sformatf("%0d", len));
        end
        else if (pick < 80)
            send_text($sformatf("%0d", 64'd1 << COUNT_BITS));
        else if (pick < 85)
            send_text("99999999999");
        else if (pick < 95)
        begin
            // count spoiled by a non-digit
            send_text($sformatf("%0d", $urandom_range(1, 9)));
            do
                b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_RBRACE);
            send_byte(b);
        end
        send_byte(CH_RBRACE);
        lf_sent = 1'($urandom_range(0, 1));
        if (lf_sent)
            send_byte(CH_LF);
        for (i = 0; i < len; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (i == 0 && !lf_sent && b == CH_LF);
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] atom_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_LPAREN || b == CH_RPAREN || b == CH_CR ||
               b == CH_LF || b == CH_QUOTE || b == CH_LBRACE);
        return b;
    endfunction

    function automatic logic [7:0] atom_stop();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = CH_SPACE;
            1:       b = CH_LPAREN;
            2:       b = CH_RPAREN;
            3:       b = CH_CR;
            4:       b = CH_LF;
            default: b = CH_QUOTE;
        endcase
        return b;
    endfunction

    task automatic send_atom();
        int pick;
        int len;
        int i;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 5);
        if (pick < 20)
        begin
            send_text("NIL");
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        end
        else if (pick < 35)
            send_text(($urandom_range(0, 1) == 0) ? "N" : "NI");
        else if (pick < 92)
            send_byte(atom_char());
        else
            len = 0;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) send_byte(CH_BSLASH);
            else
                send_byte(atom_char());
        end
        send_byte(atom_stop());
    endtask

    // Run limit
    initial
    begin
        #5_000_000;
        $display("imap_string_token_decoder verification failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int   start;
        int   pick;
        logic paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quoted: CR escape, backslash escape, then an unsupported escape
        send_text("\"\\r\\\\\\x");
        // spoiled count reads as zero; the LF after it is dropped
        send_text("{1x}");
        send_byte(CH_LF);
        // terminator with no atom in front of it
        send_byte(CH_LPAREN);
        send_text("NIL ");
        // broken NIL prefix, backslash run, atom closed by a quote
        send_text("NI\\\\X\"");
        // literal carrying the byte extremes, no LF after the brace
        send_text("{2}");
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();

        // random token stream with some noise
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_quoted();
            else if (pick < 45)
                send_literal();
            else if (pick < 90)
                send_atom();
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            if (pick < 45 && $urandom_range(0, 2) != 0)
                send_byte(CH_SPACE);
            if ($urandom_range(0, 9) == 0)
                quiet <= ~quiet;
            if (!paused && sent_bytes - start > RANDOM_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end

        // largest legal count; only its first bytes are sent
        send_text($sformatf("{%0d}", (64'd1 << COUNT_BITS) - 64'd1));
        send_byte(CH_LF);
        repeat (3) send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("imap_string_token_decoder verification clean");
        else
            $display("imap_string_token_decoder verification failed");
        $finish;
    end

endmodule

@@ files.f @@
src/imapstd_pkg.sv
src/imapstd_fifo.sv
src/imap_string_token_decoder.sv
tb/sv/imap_token_checker.sv
tb/sv/imap_string_token_decoder_test.sv
